>>> rtl/hcfc_pkg.sv
// ----------------------------------------------------------------------------
// hcfc_pkg
// Shared types and constants for the humidity/temperature frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hcfc_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]         CRC_POLY    = 8'h31;
   localparam logic [15:0]        RAW_MASK    = 16'hFFFC;
   localparam logic [14:0]        TEMP_SPAN   = 15'd17572;
   localparam logic [14:0]        HUMI_SPAN   = 15'd12500;
   localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
   localparam logic signed [15:0] HUMI_OFFSET = -16'sd600;
   localparam logic [13:0]        HUMI_MAX    = 14'd10000;

   localparam logic signed [14:0] TEMP_HIGH_RESET = 15'sd3500;
   localparam logic signed [14:0] TEMP_LOW_RESET  = 15'sd500;
   localparam logic [13:0]        HUMI_HIGH_RESET = 14'd8000;

   typedef enum logic [1:0] {
      CSR_TEMP_HIGH = 2'd0,
      CSR_TEMP_LOW  = 2'd1,
      CSR_HUMI_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_CRC = 2'd1,
      STATUS_BUS = 2'd2
   } status_type;

   // classified frame as it travels from front to back
   typedef struct packed {
      logic        mode;
      status_type  status;
      logic [15:0] raw;
   } item_type;

endpackage

`default_nettype wire

>>> rtl/humidity_temp_frame_checker.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// A result passes the front register, the queue and the scale stage before the result register.
// Throughput: one item per cycle while results are not stalled, set by the single multiplier in the back.
// A 4-entry queue lets the front keep taking items while results are stalled.
// Synchronous reset clears the stored readings to zero and the limits to
// their defaults; no item or result is held after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_checker #(
   parameter int QUEUE_DEPTH = hcfc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [14:0]       csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic              req_bus_failed,
   input  wire logic [7:0]        req_data_high,
   input  wire logic [7:0]        req_data_low,
   input  wire logic [7:0]        req_check_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic signed [14:0]     rsp_reading,
   output logic                   rsp_alarm_hot,
   output logic                   rsp_alarm_cold,
   output logic                   rsp_alarm_damp
);

   logic               push, full, pop, pop_valid;
   hcfc_pkg::item_type push_item, pop_item;

   hcfc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_bus_failed (req_bus_failed),
      .req_data_high  (req_data_high),
      .req_data_low   (req_data_low),
      .req_check_byte (req_check_byte),
      .push           (push),
      .push_item      (push_item),
      .queue_full     (full)
   );

   hcfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   hcfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .item_valid     (pop_valid),
      .item           (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_reading    (rsp_reading),
      .rsp_alarm_hot  (rsp_alarm_hot),
      .rsp_alarm_cold (rsp_alarm_cold),
      .rsp_alarm_damp (rsp_alarm_damp)
   );

endmodule

`default_nettype wire

>>> rtl/hcfc_front.sv
// ----------------------------------------------------------------------------
// hcfc_front
// Accepts frames, runs the CRC-8 over the data bytes and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module hcfc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic              req_bus_failed,
   input  wire logic [7:0]        req_data_high,
   input  wire logic [7:0]        req_data_low,
   input  wire logic [7:0]        req_check_byte,
   output logic                   push,
   output hcfc_pkg::item_type     push_item,
   input  wire logic              queue_full
);

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ hcfc_pkg::CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   logic       valid_ff, valid_in;
   logic       mode_ff, bus_ff;
   logic [7:0] high_ff, low_ff, check_ff, part_ff;
   logic       load;
   logic [7:0] crc;

   assign req_stall = valid_ff && queue_full;
   assign load      = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   // first byte of the CRC is done at acceptance, second one here
   assign crc = crc8_byte(part_ff, low_ff);

   always_comb begin
      push_item.mode = mode_ff;
      push_item.raw  = {high_ff, low_ff} & hcfc_pkg::RAW_MASK;
      if (bus_ff) begin
         push_item.status = hcfc_pkg::STATUS_BUS;
      end else if (crc != check_ff) begin
         push_item.status = hcfc_pkg::STATUS_CRC;
      end else begin
         push_item.status = hcfc_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff  <= req_mode;
         bus_ff   <= req_bus_failed;
         high_ff  <= req_data_high;
         low_ff   <= req_data_low;
         check_ff <= req_check_byte;
         part_ff  <= crc8_byte(8'h00, req_data_high);
      end
   end

endmodule

`default_nettype wire

>>> rtl/hcfc_queue.sv
// ----------------------------------------------------------------------------
// hcfc_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcfc_queue #(
   parameter int DEPTH = hcfc_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  hcfc_pkg::item_type      push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output hcfc_pkg::item_type      pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   hcfc_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hcfc_back.sv
// ----------------------------------------------------------------------------
// hcfc_back
// Scales raw words, keeps the stored readings and limits, raises the alarms
// and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcfc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_data,
   input  wire logic               item_valid,
   input  hcfc_pkg::item_type      item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [14:0]      rsp_reading,
   output logic                    rsp_alarm_hot,
   output logic                    rsp_alarm_cold,
   output logic                    rsp_alarm_damp
);

   // limits
   logic signed [14:0] temp_high_ff, temp_low_ff;
   logic [13:0]        humi_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_high_ff <= hcfc_pkg::TEMP_HIGH_RESET;
         temp_low_ff  <= hcfc_pkg::TEMP_LOW_RESET;
         humi_high_ff <= hcfc_pkg::HUMI_HIGH_RESET;
      end else if (csr_write) begin
         case (hcfc_pkg::csr_index_type'(csr_index))
            hcfc_pkg::CSR_TEMP_HIGH: temp_high_ff <= csr_data;
            hcfc_pkg::CSR_TEMP_LOW:  temp_low_ff  <= csr_data;
            hcfc_pkg::CSR_HUMI_HIGH: humi_high_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   // scale stage
   logic                 a_valid_ff, a_valid_in;
   logic                 a_mode_ff;
   hcfc_pkg::status_type a_status_ff;
   logic [14:0]          a_scaled_ff;
   logic [14:0]          span;
   logic [30:0]          product;
   logic                 a_ready, o_ready, o_load;

   assign o_ready = !rsp_valid || !rsp_stall;
   assign o_load  = a_valid_ff && o_ready;
   assign a_ready = !a_valid_ff || o_ready;
   assign pop     = item_valid && a_ready;

   assign span    = item.mode ? hcfc_pkg::HUMI_SPAN : hcfc_pkg::TEMP_SPAN;
   assign product = {16'd0, span} * {15'd0, item.raw};

   assign a_valid_in = a_ready ? item_valid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         a_mode_ff   <= item.mode;
         a_status_ff <= item.status;
         a_scaled_ff <= product[30:16];
      end
   end

   // offset, clamp and stored values
   logic signed [14:0] last_temp_ff, last_temp_in;
   logic [13:0]        last_humi_ff, last_humi_in;
   logic signed [15:0] temp_wide, humi_wide;

   assign temp_wide = $signed({1'b0, a_scaled_ff}) + hcfc_pkg::TEMP_OFFSET;
   assign humi_wide = $signed({1'b0, a_scaled_ff}) + hcfc_pkg::HUMI_OFFSET;

   always_comb begin
      last_temp_in = last_temp_ff;
      last_humi_in = last_humi_ff;
      if (a_status_ff == hcfc_pkg::STATUS_OK) begin
         if (!a_mode_ff) begin
            last_temp_in = temp_wide[14:0];
         end else if (humi_wide[15]) begin
            last_humi_in = '0;
         end else if (humi_wide > $signed({2'b00, hcfc_pkg::HUMI_MAX})) begin
            last_humi_in = hcfc_pkg::HUMI_MAX;
         end else begin
            last_humi_in = humi_wide[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid    <= 1'b0;
         last_temp_ff <= '0;
         last_humi_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (o_ready) begin
            rsp_valid <= a_valid_ff;
         end
         if (o_load) begin
            last_temp_ff <= last_temp_in;
            last_humi_ff <= last_humi_in;
         end
      end
   end

   // result register, alarms from the values after this item
   always_ff @(posedge clock) begin
      if (o_load) begin
         rsp_status     <= a_status_ff;
         rsp_reading    <= a_mode_ff ? $signed({1'b0, last_humi_in}) : last_temp_in;
         rsp_alarm_hot  <= last_temp_in > temp_high_ff;
         rsp_alarm_cold <= last_temp_in < temp_low_ff;
         rsp_alarm_damp <= last_humi_in > humi_high_ff;
      end
   end

endmodule

`default_nettype wire
